/* hdl/frame_length_checksum_check_assert.svh */
// Assertion macros for the frame checker. Each one is clocked on clk and
// switched off while arst_n is low.
`ifndef FRAME_LENGTH_CHECKSUM_CHECK_ASSERT_SVH
`define FRAME_LENGTH_CHECKSUM_CHECK_ASSERT_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define FLCC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define FLCC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define FLCC_ASSERT_IMP(label, ante, cons, msg)
`define FLCC_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

/* hdl/flcc_pkg.sv */
package flcc_pkg;

	localparam int BYTE_W  = 8;
	localparam int WORD_W  = 16;
	localparam int COUNT_W = 17;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	// Two length bytes and two checksum bytes frame the payload.
	localparam logic [COUNT_W-1:0] MIN_FRAME = COUNT_W'(4);

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SHORT = 2'd1,
		ST_SUM   = 2'd2,
		ST_LEN   = 2'd3
	} status_t;

	typedef struct packed {
		logic              valid;
		logic              last;
		logic [BYTE_W-1:0] data;
	} in_item_t;

	typedef struct packed {
		status_t           status;
		logic [WORD_W-1:0] declared_length;
		logic [WORD_W-1:0] computed_sum;
	} result_t;

endpackage

/* hdl/flcc_in_reg.sv */
module flcc_in_reg
	import flcc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              is_last,
	input  logic              advance,
	output logic              in_ready,
	output in_item_t          item_s1
);

	logic              valid_s1;
	logic              last_s1;
	logic [BYTE_W-1:0] data_s1;

	// The stage takes a new item whenever it is empty or its item moves on.
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_byte;
			last_s1 <= is_last;
		end
	end

	assign item_s1 = '{valid: valid_s1, last: last_s1, data: data_s1};

endmodule

/* hdl/flcc_frame.sv */
module flcc_frame
	import flcc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     advance,
	input  in_item_t item_s1,
	output result_t  res
);

	logic [COUNT_W-1:0] count_q;
	logic [BYTE_W-1:0]  older_q;
	logic [BYTE_W-1:0]  newer_q;
	logic [WORD_W-1:0]  lagged_q;
	logic [WORD_W-1:0]  length_q;

	logic [COUNT_W-1:0] count_nx;
	logic [COUNT_W-1:0] payload_cnt;
	logic [WORD_W-1:0]  lagged_nx;
	logic [WORD_W-1:0]  length_nx;
	logic [WORD_W-1:0]  received;

	always_comb begin
		// Only bytes at least two places behind the newest one join the sum.
		if (count_q[COUNT_W-1:1] != '0) begin
			lagged_nx = lagged_q + WORD_W'(older_q);
		end else begin
			lagged_nx = lagged_q;
		end

		if (count_q == '0) begin
			length_nx = {item_s1.data, length_q[BYTE_W-1:0]};
		end else if (count_q == COUNT_W'(1)) begin
			length_nx = {length_q[WORD_W-1:BYTE_W], item_s1.data};
		end else begin
			length_nx = length_q;
		end

		count_nx    = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_W'(1);
		payload_cnt = count_nx - MIN_FRAME;
		received    = {newer_q, item_s1.data};

		if (count_nx <= MIN_FRAME) begin
			res = '{status: ST_SHORT, declared_length: '0, computed_sum: '0};
		end else begin
			res.declared_length = length_nx;
			res.computed_sum    = lagged_nx;
			if (received != lagged_nx) begin
				res.status = ST_SUM;
			end else if (payload_cnt != {1'b0, length_nx}) begin
				res.status = ST_LEN;
			end else begin
				res.status = ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			older_q  <= '0;
			newer_q  <= '0;
			lagged_q <= '0;
			length_q <= '0;
		end else if (advance) begin
			if (item_s1.last) begin
				count_q  <= '0;
				older_q  <= '0;
				newer_q  <= '0;
				lagged_q <= '0;
				length_q <= '0;
			end else begin
				count_q  <= count_nx;
				older_q  <= newer_q;
				newer_q  <= item_s1.data;
				lagged_q <= lagged_nx;
				length_q <= length_nx;
			end
		end
	end

endmodule

/* hdl/flcc_out_reg.sv */
module flcc_out_reg
	import flcc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  result_t           res,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [1:0]        status,
	output logic [WORD_W-1:0] declared_length,
	output logic [WORD_W-1:0] computed_sum
);

	logic    valid_q;
	result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_valid       = valid_q;
	assign status          = 2'(res_q.status);
	assign declared_length = res_q.declared_length;
	assign computed_sum    = res_q.computed_sum;

endmodule

/* hdl/frame_length_checksum_check.sv */
// Frame length and checksum checker. Frame bytes enter one per item, with
// is_last high on the final byte; a frame is a 16-bit big-endian length, the
// payload, then a 16-bit big-endian sum (mod 65536) of every earlier byte.
// Only the final byte gives a result: status (too short, checksum mismatch,
// length mismatch, checked in that order, else ok), the declared length and
// the computed sum. The block takes one byte per clock cycle unless the input
// stalls; each byte passes an input register and, if it ends a frame, moves
// on from there into the result register, which holds the verdict until it
// is taken. Input stalls only while a verdict waits in the result register
// and the final byte of the next frame is already held.
`include "frame_length_checksum_check_assert.svh"

module frame_length_checksum_check
	import flcc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              is_last,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic [WORD_W-1:0] declared_length,
	output logic [WORD_W-1:0] computed_sum
);

	in_item_t item_s1;
	result_t  res;
	logic     advance;
	logic     load;

	// A byte that is not final never needs the result register.
	assign advance = item_s1.valid && (!item_s1.last || !out_valid || out_ready);
	assign load    = advance && item_s1.last;

	flcc_in_reg u_in_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.data_byte (data_byte),
		.is_last   (is_last),
		.advance   (advance),
		.in_ready  (in_ready),
		.item_s1   (item_s1)
	);

	flcc_frame u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item_s1 (item_s1),
		.res     (res)
	);

	flcc_out_reg u_out_reg (
		.clk             (clk),
		.arst_n          (arst_n),
		.load            (load),
		.res             (res),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.status          (status),
		.declared_length (declared_length),
		.computed_sum    (computed_sum)
	);

	`FLCC_ASSERT_NXT(a_final_gives_result, load, out_valid, "final byte gave no result")
	`FLCC_ASSERT_IMP(a_stall_cause, !in_ready,
		item_s1.valid && item_s1.last && out_valid && !out_ready, "input stalled without cause")
	`FLCC_ASSERT_IMP(a_short_zero, out_valid && (status == ST_SHORT),
		(declared_length == '0) && (computed_sum == '0), "short frame with nonzero fields")
	`FLCC_ASSERT_NXT(a_hold_result, out_valid && !out_ready && !load,
		out_valid && $stable(status) && $stable(computed_sum), "stalled result changed")

endmodule
